// ===== rtl/core/neighbour_link_quality_table_defines.svh =====
// neighbour_link_quality_table_defines.svh
// assertion macros for the link quality table checker, no dependencies
// clk and rst_n are taken from the scope that expands a macro

`ifndef NEIGHBOUR_LINK_QUALITY_TABLE_DEFINES_SVH
`define NEIGHBOUR_LINK_QUALITY_TABLE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NLQT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nlqt check failed");

// next-cycle implication, disabled in reset
`define NLQT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nlqt check failed");

`endif

// ===== rtl/core/nlqt_pkg.sv =====
// nlqt_pkg.sv
// shared constants, status codes and the queued word type of the link quality table
// no dependencies

package nlqt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int FIELD_W     = 16;
    localparam int STATUS_W    = 3;
    localparam int ENTRY_IDX_W = 4;

    localparam logic CMD_PING   = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_UPDATED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REPORT_ENTRY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REPORT_EMPTY = 3'd4;

    typedef struct packed {
        logic               is_report;
        logic [FIELD_W-1:0] addr;
        logic [FIELD_W-1:0] strength;
        logic [FIELD_W-1:0] quality;
    } op_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

endpackage

// ===== rtl/core/neighbour_link_quality_table.sv =====
// neighbour_link_quality_table.sv
// top level of the neighbour link quality table
// depends on nlqt_pkg, nlqt_front, nlqt_queue and nlqt_back
//
// usage:
//   request channel (req_valid / req_stall): one word per event, cmd selects
//   a ping (address, strength, quality) or a report tick
//   response channel (rsp_valid / rsp_stall): a ping gives one word with
//   status updated, inserted or dropped; a report gives one word per filled
//   slot in slot order, or a single report-empty word; last marks the final
//   word of each event
//   flow: a request word is registered, queued, then scanned one table
//   slot per cycle, unless a stalled response holds the scan, through the
//   single read port of the table memory; a report then gives one word per
//   cycle while the response is not stalled; the back part takes the next
//   event from the queue only once the last one is done, the scan covering
//   the filled slots (at most 16)
//   reset: clears the fill count, the queue and all valids; table contents
//   stay undefined and are never read before written
//   stall: a held response keeps its word; a report scan or a ping result waits
//   while the request side keeps filling the two-word queue, then stalls

module neighbour_link_quality_table
(
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                cmd,
    input  logic [nlqt_pkg::FIELD_W-1:0]        sender_address,
    input  logic [nlqt_pkg::FIELD_W-1:0]        signal_strength,
    input  logic [nlqt_pkg::FIELD_W-1:0]        link_quality,
    // response channel
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [nlqt_pkg::STATUS_W-1:0]       status,
    output logic [nlqt_pkg::ENTRY_IDX_W-1:0]    entry_index,
    output logic [nlqt_pkg::FIELD_W-1:0]        entry_address,
    output logic [nlqt_pkg::FIELD_W-1:0]        entry_strength,
    output logic [nlqt_pkg::FIELD_W-1:0]        entry_quality,
    output logic                                last
);

    nlqt_pkg::queue_status_t q_status;
    nlqt_pkg::op_t           push_word;
    nlqt_pkg::op_t           pop_word;
    logic                    push;
    logic                    pop;

    // front: registers and classifies the request word
    nlqt_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .cmd             (cmd),
        .sender_address  (sender_address),
        .signal_strength (signal_strength),
        .link_quality    (link_quality),
        .q_status        (q_status),
        .push            (push),
        .push_word       (push_word)
    );

    // two-word queue decouples the two sides
    nlqt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .q_status  (q_status)
    );

    // back: table scan, update / insert and report stream
    nlqt_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .pop_word       (pop_word),
        .pop            (pop),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .entry_index    (entry_index),
        .entry_address  (entry_address),
        .entry_strength (entry_strength),
        .entry_quality  (entry_quality),
        .last           (last)
    );

endmodule

// ===== rtl/core/nlqt_front.sv =====
// nlqt_front.sv
// input stage: registers one word, classifies it as ping or report and hands it on
// depends on nlqt_pkg

module nlqt_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic                              cmd,
    input  logic [nlqt_pkg::FIELD_W-1:0]      sender_address,
    input  logic [nlqt_pkg::FIELD_W-1:0]      signal_strength,
    input  logic [nlqt_pkg::FIELD_W-1:0]      link_quality,
    input  nlqt_pkg::queue_status_t           q_status,
    output logic                              push,
    output nlqt_pkg::op_t                     push_word
);

    logic          word_valid_reg;
    logic          word_valid_next;
    nlqt_pkg::op_t word_reg;
    logic          accept;

    assign req_stall = word_valid_reg && q_status.full;
    assign accept    = req_valid && !req_stall;
    assign push      = word_valid_reg && !q_status.full;
    assign push_word = word_reg;

    always_comb
    begin
        word_valid_next = word_valid_reg;
        if (accept)
        begin
            word_valid_next = 1'b1;
        end
        else if (push)
        begin
            word_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
        end
        else
        begin
            word_valid_reg <= word_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.is_report <= (cmd == nlqt_pkg::CMD_REPORT);
            word_reg.addr      <= sender_address;
            word_reg.strength  <= signal_strength;
            word_reg.quality   <= link_quality;
        end
    end

endmodule

// ===== rtl/core/nlqt_queue.sv =====
// nlqt_queue.sv
// short word queue between the front and back parts
// depends on nlqt_pkg

module nlqt_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  nlqt_pkg::op_t           push_word,
    input  logic                    pop,
    output nlqt_pkg::op_t           pop_word,
    output nlqt_pkg::queue_status_t q_status
);

    nlqt_pkg::op_t                      slot_reg [nlqt_pkg::QUEUE_DEPTH];
    logic [nlqt_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [nlqt_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [nlqt_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [nlqt_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [nlqt_pkg::QFILL_W-1:0]       fill_reg;
    logic [nlqt_pkg::QFILL_W-1:0]       fill_next;
    logic                               do_push;
    logic                               do_pop;

    localparam logic [nlqt_pkg::QPTR_W-1:0]  PTR_LAST =
        nlqt_pkg::QPTR_W'(nlqt_pkg::QUEUE_DEPTH - 1);
    localparam logic [nlqt_pkg::QFILL_W-1:0] FILL_FULL =
        nlqt_pkg::QFILL_W'(nlqt_pkg::QUEUE_DEPTH);

    assign q_status.valid = (fill_reg != '0);
    assign q_status.full  = (fill_reg == FILL_FULL);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && q_status.valid;
    assign pop_word       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== rtl/core/nlqt_back.sv =====
// nlqt_back.sv
// back part: table memories, scan sequencer and result register
// depends on nlqt_pkg

module nlqt_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  nlqt_pkg::queue_status_t             q_status,
    input  nlqt_pkg::op_t                       pop_word,
    output logic                                pop,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [nlqt_pkg::STATUS_W-1:0]       status,
    output logic [nlqt_pkg::ENTRY_IDX_W-1:0]    entry_index,
    output logic [nlqt_pkg::FIELD_W-1:0]        entry_address,
    output logic [nlqt_pkg::FIELD_W-1:0]        entry_strength,
    output logic [nlqt_pkg::FIELD_W-1:0]        entry_quality,
    output logic                                last
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    localparam logic [nlqt_pkg::CNT_W-1:0] CNT_FULL = nlqt_pkg::CNT_W'(nlqt_pkg::TABLE_DEPTH);

    // table memories
    logic [nlqt_pkg::FIELD_W-1:0] addr_mem [nlqt_pkg::TABLE_DEPTH];
    logic [nlqt_pkg::FIELD_W-1:0] str_mem  [nlqt_pkg::TABLE_DEPTH];
    logic [nlqt_pkg::FIELD_W-1:0] qual_mem [nlqt_pkg::TABLE_DEPTH];

    logic                             state_reg;
    logic                             state_next;
    nlqt_pkg::op_t                    op_reg;
    logic [nlqt_pkg::CNT_W-1:0]       count_reg;
    logic [nlqt_pkg::CNT_W-1:0]       count_next;
    logic [nlqt_pkg::CNT_W-1:0]       issue_reg;
    logic [nlqt_pkg::CNT_W-1:0]       issue_next;
    logic                             rd_valid_reg;
    logic                             rd_valid_next;
    logic [nlqt_pkg::IDX_W-1:0]       rd_idx_reg;
    logic [nlqt_pkg::FIELD_W-1:0]     rd_addr_reg;
    logic [nlqt_pkg::FIELD_W-1:0]     rd_str_reg;
    logic [nlqt_pkg::FIELD_W-1:0]     rd_qual_reg;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [nlqt_pkg::STATUS_W-1:0]    out_status_reg;
    logic [nlqt_pkg::STATUS_W-1:0]    out_status_next;
    logic [nlqt_pkg::ENTRY_IDX_W-1:0] out_index_reg;
    logic [nlqt_pkg::ENTRY_IDX_W-1:0] out_index_next;
    logic [nlqt_pkg::FIELD_W-1:0]     out_addr_reg;
    logic [nlqt_pkg::FIELD_W-1:0]     out_addr_next;
    logic [nlqt_pkg::FIELD_W-1:0]     out_str_reg;
    logic [nlqt_pkg::FIELD_W-1:0]     out_str_next;
    logic [nlqt_pkg::FIELD_W-1:0]     out_qual_reg;
    logic [nlqt_pkg::FIELD_W-1:0]     out_qual_next;
    logic                             out_last_reg;
    logic                             out_last_next;

    logic                             out_free;
    logic                             scanning;
    logic                             hit;
    logic                             consume;
    logic                             issue;
    logic                             scan_done;
    logic                             emit;
    logic                             upd_en;
    logic                             ins_en;
    logic                             table_full;
    logic                             rd_is_last;

    assign out_free   = !out_valid_reg || !rsp_stall;
    assign scanning   = (state_reg == S_SCAN);
    assign table_full = (count_reg == CNT_FULL);
    assign hit        = scanning && rd_valid_reg && !op_reg.is_report
                        && (rd_addr_reg == op_reg.addr);
    // a miss on a ping frees the read register without needing the output
    assign consume    = scanning && rd_valid_reg && (out_free || (!op_reg.is_report && !hit));
    assign issue      = scanning && (issue_reg < count_reg) && (!rd_valid_reg || consume);
    assign scan_done  = scanning && !rd_valid_reg && (issue_reg == count_reg);
    assign upd_en     = hit && out_free;
    assign ins_en     = scan_done && out_free && !op_reg.is_report && !table_full;
    assign rd_is_last = ((nlqt_pkg::CNT_W'(rd_idx_reg) + nlqt_pkg::CNT_W'(1)) == count_reg);
    assign pop        = (state_reg == S_IDLE) && q_status.valid;
    assign emit       = (consume && (op_reg.is_report || hit))
                        || (scan_done && out_free
                            && (!op_reg.is_report || (count_reg == '0)));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        rd_valid_next = rd_valid_reg;

        if (issue)
        begin
            issue_next    = issue_reg + 1'b1;
            rd_valid_next = 1'b1;
        end
        else if (consume)
        begin
            rd_valid_next = 1'b0;
        end

        if (ins_en)
        begin
            count_next = count_reg + 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    state_next    = S_SCAN;
                    issue_next    = '0;
                    rd_valid_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (upd_en || (scan_done && out_free))
                begin
                    state_next    = S_IDLE;
                    rd_valid_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result word
    always_comb
    begin
        out_valid_next  = out_valid_reg && rsp_stall;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_addr_next   = out_addr_reg;
        out_str_next    = out_str_reg;
        out_qual_next   = out_qual_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            priority if (op_reg.is_report && rd_valid_reg)
            begin
                out_status_next = nlqt_pkg::ST_REPORT_ENTRY;
                out_index_next  = nlqt_pkg::ENTRY_IDX_W'(rd_idx_reg);
                out_addr_next   = rd_addr_reg;
                out_str_next    = rd_str_reg;
                out_qual_next   = rd_qual_reg;
                out_last_next   = rd_is_last;
            end
            else if (op_reg.is_report)
            begin
                out_status_next = nlqt_pkg::ST_REPORT_EMPTY;
                out_index_next  = '0;
                out_addr_next   = '0;
                out_str_next    = '0;
                out_qual_next   = '0;
            end
            else if (hit)
            begin
                out_status_next = nlqt_pkg::ST_UPDATED;
                out_index_next  = nlqt_pkg::ENTRY_IDX_W'(rd_idx_reg);
                out_addr_next   = op_reg.addr;
                out_str_next    = op_reg.strength;
                out_qual_next   = op_reg.quality;
            end
            else if (table_full)
            begin
                out_status_next = nlqt_pkg::ST_DROPPED;
                out_index_next  = '0;
                out_addr_next   = op_reg.addr;
                out_str_next    = op_reg.strength;
                out_qual_next   = op_reg.quality;
            end
            else
            begin
                out_status_next = nlqt_pkg::ST_INSERTED;
                out_index_next  = nlqt_pkg::ENTRY_IDX_W'(count_reg);
                out_addr_next   = op_reg.addr;
                out_str_next    = op_reg.strength;
                out_qual_next   = op_reg.quality;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg <= pop_word;
        end
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_addr_reg   <= out_addr_next;
        out_str_reg    <= out_str_next;
        out_qual_reg   <= out_qual_next;
        out_last_reg   <= out_last_next;
    end

    // memory read port, data registered with its slot number
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_idx_reg  <= issue_reg[nlqt_pkg::IDX_W-1:0];
            rd_addr_reg <= addr_mem[issue_reg[nlqt_pkg::IDX_W-1:0]];
            rd_str_reg  <= str_mem[issue_reg[nlqt_pkg::IDX_W-1:0]];
            rd_qual_reg <= qual_mem[issue_reg[nlqt_pkg::IDX_W-1:0]];
        end
    end

    // memory write port
    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            addr_mem[count_reg[nlqt_pkg::IDX_W-1:0]] <= op_reg.addr;
            str_mem[count_reg[nlqt_pkg::IDX_W-1:0]]  <= op_reg.strength;
            qual_mem[count_reg[nlqt_pkg::IDX_W-1:0]] <= op_reg.quality;
        end
        else if (upd_en)
        begin
            str_mem[rd_idx_reg]  <= op_reg.strength;
            qual_mem[rd_idx_reg] <= op_reg.quality;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign entry_index    = out_index_reg;
    assign entry_address  = out_addr_reg;
    assign entry_strength = out_str_reg;
    assign entry_quality  = out_qual_reg;
    assign last           = out_last_reg;

endmodule

// ===== rtl/core/nlqt_checker.sv =====
// nlqt_checker.sv
// port-level assertions for the link quality table, bound to the top level
// depends on nlqt_pkg and neighbour_link_quality_table_defines.svh

`include "neighbour_link_quality_table_defines.svh"

module nlqt_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rsp_valid,
    input  logic                                rsp_stall,
    input  logic [nlqt_pkg::STATUS_W-1:0]       status,
    input  logic [nlqt_pkg::ENTRY_IDX_W-1:0]    entry_index,
    input  logic [nlqt_pkg::FIELD_W-1:0]        entry_address,
    input  logic                                last
);

    logic                                             rsp_held;
    logic [nlqt_pkg::STATUS_W+nlqt_pkg::FIELD_W:0]    held_word;
    logic                                             single_word_kind;
    logic                                             slot_zero_kind;

    assign rsp_held         = rsp_valid && rsp_stall;
    assign held_word        = {status, entry_address, last};
    assign single_word_kind = rsp_valid && (status != nlqt_pkg::ST_REPORT_ENTRY);
    assign slot_zero_kind   = rsp_valid
                              && ((status == nlqt_pkg::ST_DROPPED)
                                  || (status == nlqt_pkg::ST_REPORT_EMPTY));

    // a held response stays up with the same status, address and last flag
    `NLQT_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid)
    `NLQT_ASSERT_NEXT(a_rsp_stable, rsp_held, $stable(held_word))

    // only report entries may be non-final
    `NLQT_ASSERT_NOW(a_single_last, single_word_kind, last)

    // drop and empty report carry slot zero
    `NLQT_ASSERT_NOW(a_zero_index, slot_zero_kind, entry_index == '0)

endmodule

bind neighbour_link_quality_table nlqt_checker u_nlqt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .entry_index   (entry_index),
    .entry_address (entry_address),
    .last          (last)
);
